@@ rtl/smpq_pkg.sv @@
// shared types, codes and the ordering function for the stable min priority queue
// used by smpq_ctrl, smpq_dpath and stable_min_priority_queue; no dependencies
`default_nettype none

package smpq_pkg;

    // field widths fixed by the interface
    localparam int PRI_W   = 16;
    localparam int STAMP_W = 32;
    localparam int DATA_W  = 32;
    localparam int OCC_W   = 7;
    localparam int STAT_W  = 2;

    // command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    // one heap slot
    typedef struct packed {
        logic [PRI_W-1:0]   priority_val;
        logic [STAMP_W-1:0] stamp;
        logic [DATA_W-1:0]  payload;
    } entry_t;

    // read address selection for the two memory read ports
    typedef enum logic [1:0] {
        RD_ROOT_LAST = 2'd0,
        RD_PARENT    = 2'd1,
        RD_CHILDREN  = 2'd2
    } rd_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic    accept;
        logic    load_root;
        logic    step_up;
        logic    step_down;
        logic    place;
        logic    post;
        rd_sel_t rd_sel;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic deq_req;
        logic full;
        logic empty;
        logic pos_zero;
        logic up_move;
        logic down_end;
        logic down_move;
    } dp_stat_t;

    // true when entry a is served before entry b: lower priority, then earlier stamp
    function automatic logic precedes(entry_t a, entry_t b);
        logic [STAMP_W-1:0] diff;
        diff = a.stamp - b.stamp;
        if (a.priority_val != b.priority_val) begin
            return a.priority_val < b.priority_val;
        end
        return diff[STAMP_W-1];
    endfunction

endpackage

`default_nettype wire

@@ rtl/smpq_dpath.sv @@
// heap datapath: slot memory, moving entry, hole position, counters and result registers
// depends on smpq_pkg; driven by smpq_ctrl through dp_cmd_t
`default_nettype none

module smpq_dpath
    import smpq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_command,
    input  wire logic [PRI_W-1:0]  in_priority,
    input  wire logic [DATA_W-1:0] in_payload,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    output logic [PRI_W-1:0]       out_priority,
    output logic [DATA_W-1:0]      out_payload,
    output logic [STAT_W-1:0]      out_status,
    output logic [OCC_W-1:0]       out_occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = AW + 2;

    // heap storage
    entry_t mem [DEPTH];

    logic [CW-1:0]      count_reg, count_next;
    logic [STAMP_W-1:0] arrival_reg;
    entry_t             item_reg;
    logic [AW-1:0]      pos_reg;
    entry_t             rd_a_reg, rd_b_reg;
    logic [PRI_W-1:0]   res_pri_reg;
    logic [DATA_W-1:0]  res_pay_reg;
    logic [STAT_W-1:0]  res_status_reg;
    logic [OCC_W-1:0]   res_occ_reg;
    logic [PRI_W-1:0]   out_pri_reg;
    logic [DATA_W-1:0]  out_pay_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [OCC_W-1:0]   out_occ_reg;

    logic [AW-1:0] pos_m1, par_idx, last_idx, child_idx;
    logic [CW-1:0] count_m1;
    logic [LW-1:0] l_idx, r_idx, count_ext;
    logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
    logic          wr_en;
    entry_t        wr_data, child_ent, new_ent;
    logic          full, empty, deq_req, r_valid;
    logic          l_prec_item, r_prec_item, r_prec_l, take_r;

    // index arithmetic
    always_comb begin
        pos_m1    = pos_reg - AW'(1);
        par_idx   = pos_m1 >> 1;
        count_m1  = count_reg - CW'(1);
        last_idx  = count_m1[AW-1:0];
        l_idx     = {1'b0, pos_reg, 1'b1};
        r_idx     = l_idx + LW'(1);
        count_ext = LW'(count_reg);
        r_valid   = r_idx < count_ext;
        full      = count_reg == CW'(DEPTH);
        empty     = count_reg == '0;
        deq_req   = in_command == CMD_DEQ;
    end

    // sift-down choice, same order of tests as a swap-based sift-down
    always_comb begin
        l_prec_item = precedes(rd_a_reg, item_reg);
        r_prec_item = precedes(rd_b_reg, item_reg);
        r_prec_l    = precedes(rd_b_reg, rd_a_reg);
        take_r      = r_valid && (l_prec_item ? r_prec_l : r_prec_item);
        child_ent   = take_r ? rd_b_reg : rd_a_reg;
        child_idx   = take_r ? r_idx[AW-1:0] : l_idx[AW-1:0];
    end

    // status to the controller
    always_comb begin
        stat.deq_req   = deq_req;
        stat.full      = full;
        stat.empty     = empty;
        stat.pos_zero  = pos_reg == '0;
        stat.up_move   = precedes(item_reg, rd_a_reg);
        stat.down_end  = l_idx >= count_ext;
        stat.down_move = take_r || l_prec_item;
    end

    // read address selection
    always_comb begin
        case (cmd.rd_sel)
            RD_ROOT_LAST: begin
                rd_addr_a = '0;
                rd_addr_b = last_idx;
            end
            RD_PARENT: begin
                rd_addr_a = par_idx;
                rd_addr_b = par_idx;
            end
            RD_CHILDREN: begin
                rd_addr_a = l_idx[AW-1:0];
                rd_addr_b = r_idx[AW-1:0];
            end
            default: begin
                rd_addr_a = '0;
                rd_addr_b = last_idx;
            end
        endcase
    end

    // single write port into the hole
    always_comb begin
        wr_en   = cmd.step_up || cmd.step_down || cmd.place;
        wr_addr = pos_reg;
        if (cmd.step_up) begin
            wr_data = rd_a_reg;
        end else if (cmd.step_down) begin
            wr_data = child_ent;
        end else begin
            wr_data = item_reg;
        end
    end

    // heap memory, registered reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    // entry count after an accepted item
    always_comb begin
        count_next = count_reg;
        if (cmd.accept) begin
            if (deq_req && !empty) begin
                count_next = count_m1;
            end else if (!deq_req && !full) begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    // counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            arrival_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.accept && !deq_req && !full) begin
                arrival_reg <= arrival_reg + STAMP_W'(1);
            end
        end
    end

    always_comb begin
        new_ent.priority_val = in_priority;
        new_ent.stamp        = arrival_reg;
        new_ent.payload      = in_payload;
    end

    // moving entry, hole position and pending result
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            res_pri_reg <= '0;
            res_pay_reg <= '0;
            res_occ_reg <= OCC_W'(count_next);
            if (deq_req) begin
                res_status_reg <= empty ? STATUS_EMPTY : STATUS_DONE;
            end else begin
                res_status_reg <= full ? STATUS_FULL : STATUS_DONE;
                item_reg       <= new_ent;
                pos_reg        <= count_reg[AW-1:0];
            end
        end
        if (cmd.load_root) begin
            res_pri_reg <= rd_a_reg.priority_val;
            res_pay_reg <= rd_a_reg.payload;
            item_reg    <= rd_b_reg;
            pos_reg     <= '0;
        end
        if (cmd.step_up) begin
            pos_reg <= par_idx;
        end
        if (cmd.step_down) begin
            pos_reg <= child_idx;
        end
        if (cmd.post) begin
            out_pri_reg    <= res_pri_reg;
            out_pay_reg    <= res_pay_reg;
            out_status_reg <= res_status_reg;
            out_occ_reg    <= res_occ_reg;
        end
    end

    assign out_priority  = out_pri_reg;
    assign out_payload   = out_pay_reg;
    assign out_status    = out_status_reg;
    assign out_occupancy = out_occ_reg;

    // entry count never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    // a sift-up step moves the hole toward the root
    a_up_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step_up |=> pos_reg < $past(pos_reg))
        else $error("sift-up step did not move toward root");

    // a sift-down step moves the hole away from the root
    a_down_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step_down |=> pos_reg > $past(pos_reg))
        else $error("sift-down step did not move toward leaves");

endmodule

`default_nettype wire

@@ rtl/smpq_ctrl.sv @@
// controller state machine: handshakes and the sift-up / sift-down sequence
// depends on smpq_pkg; commands smpq_dpath through dp_cmd_t
`default_nettype none

module smpq_ctrl
    import smpq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_UP_CHK   = 7'b0000010,
        ST_UP_CMP   = 7'b0000100,
        ST_DEQ_LOAD = 7'b0001000,
        ST_DN_CHK   = 7'b0010000,
        ST_DN_CMP   = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_ROOT_LAST;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (stat.deq_req) begin
                        state_next = stat.empty ? ST_FINISH : ST_DEQ_LOAD;
                    end else begin
                        state_next = stat.full ? ST_FINISH : ST_UP_CHK;
                    end
                end
            end
            ST_UP_CHK: begin
                if (stat.pos_zero) begin
                    cmd.place  = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.rd_sel = RD_PARENT;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (stat.up_move) begin
                    cmd.step_up = 1'b1;
                    state_next  = ST_UP_CHK;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_DEQ_LOAD: begin
                cmd.load_root = 1'b1;
                state_next    = ST_DN_CHK;
            end
            ST_DN_CHK: begin
                if (stat.down_end) begin
                    cmd.place  = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.rd_sel = RD_CHILDREN;
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                if (stat.down_move) begin
                    cmd.step_down = 1'b1;
                    state_next    = ST_DN_CHK;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.post   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on post, cleared when taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.post) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;

    // one item at a time: no accept right after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item in work");

    // a result is posted only when the output register is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.post |-> (!m_tvalid_reg || m_tready))
        else $error("result posted over an untaken result");

    // heap writes happen only while an item is in work
    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.place || cmd.step_up || cmd.step_down) |-> !s_tready)
        else $error("heap write while idle");

endmodule

`default_nettype wire

@@ rtl/stable_min_priority_queue.sv @@
// Stable min priority queue over a binary heap of DEPTH slots. An enqueue stores a
// priority and a payload word with an arrival stamp; a dequeue returns the lowest
// priority, earliest arrival first among equals. One item is in work at a time, and
// the next item can be accepted while the previous result still waits on the output.
// A refused command (full or empty) goes straight from the accept to the finish state.
// Otherwise an enqueue sifts up, and a dequeue first loads the root and then sifts
// down; each heap level walked (at most log2(DEPTH), 6 for 64 slots) costs one
// registered memory read and one compare-and-write through the single write port of
// the slot memory. A result that still waits on the output adds its wait, and the
// next item can be taken in the cycle after the result is posted. No clearing pass
// is needed after reset.
// depends on smpq_pkg, smpq_ctrl, smpq_dpath
`default_nettype none

module stable_min_priority_queue
    import smpq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // priority_req[15:0], payload[47:16]
    input  wire logic [0:0]  s_tuser,  // command[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // out_priority[15:0], out_payload[47:16],
                                       // occupancy[54:48], zero fill[55]
    output logic [1:0]       m_tuser   // status[1:0]
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [PRI_W-1:0]  out_priority;
    logic [DATA_W-1:0] out_payload;
    logic [STAT_W-1:0] out_status;
    logic [OCC_W-1:0]  out_occupancy;

    // sequencer
    smpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // heap storage and arithmetic
    smpq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_command    (s_tuser[0]),
        .in_priority   (s_tdata[15:0]),
        .in_payload    (s_tdata[47:16]),
        .cmd           (cmd),
        .stat          (stat),
        .out_priority  (out_priority),
        .out_payload   (out_payload),
        .out_status    (out_status),
        .out_occupancy (out_occupancy)
    );

    // result packing
    assign m_tdata = {1'b0, out_occupancy, out_payload, out_priority};
    assign m_tuser = out_status;

endmodule

`default_nettype wire
